// ===== rtl/sml_pkg.sv =====
`default_nettype none

package sml_pkg;

   localparam int IDX_W      = 5;
   localparam int SIZE_W     = 16;
   localparam int ALIGN_W    = 8;
   localparam int COUNT_W    = 16;
   localparam int CNT_REG_W  = 6;
   localparam int WORD_W     = 32;
   localparam int STATUS_W   = 2;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 96;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SKIPPED = 2'd2;

   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_MEMBER = 1'b1;

   typedef struct packed {
      logic [SIZE_W-1:0]  size;
      logic [ALIGN_W-1:0] align;
   } tbl_entry_type;

endpackage

`default_nettype wire

// ===== rtl/struct_member_layout_unit.sv =====
`default_nettype none
// Structure member layout unit.
// req_* carries one beat per request. tuser = 0 loads slot type_index of the
// type table with type_size and type_alignment and returns nothing; tuser = 1
// presents a structure member, and tlast marks the final member.
// rsp_* returns one beat per member: aligned offset, length, status in tuser
// and, on the final member, the padded structure size; tlast mirrors it.
// csr_* writes the type limit, the number of valid type table entries.
// A member passes through the table read, the multiply and the add before it
// reaches the result register; an invalid or skipped member goes from the table
// read straight to it. Remainder passes take eight dividend bits per cycle:
// one aligns a nonzero offset to any alignment above 1 and one pads the final
// total. req_tready rises on the edge that fills the result register, so a
// member holds the input until its result is registered.
// The type table is a synchronous memory of MAX_TYPES entries, undefined until
// loaded. Reset clears the running offset, the error flag and the largest
// aligned type, and sets the type limit to 1.
// A finished result waits in the output register while the next request is
// accepted; if rsp_tready stays low the following member holds in its last
// step until the register frees.

module struct_member_layout_unit #(
   parameter int MAX_TYPES = 32
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // type_index[4:0], type_size[20:5], type_alignment[28:21], array_count[44:29]
   input  wire  [sml_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_type[0]
   input  wire                                req_tuser,
   input  wire                                req_tlast,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // member_offset[31:0], member_length[63:32], struct_total[95:64]
   output logic [sml_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // status[1:0]
   output logic [sml_pkg::STATUS_W-1:0]       rsp_tuser,
   output logic                               rsp_tlast,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [sml_pkg::CNT_REG_W-1:0]      csr_wdata
);

   localparam int ADDR_W = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
   localparam int WIDE_W = 9;
   localparam logic [WIDE_W-1:0] MAX_TYPES_W = WIDE_W'(MAX_TYPES);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_PAD1 = 3'd2;
   localparam logic [2:0] S_ADD  = 3'd3;
   localparam logic [2:0] S_PAD2 = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   localparam int W  = sml_pkg::WORD_W;
   localparam int AW = sml_pkg::ALIGN_W;

   sml_pkg::tbl_entry_type tbl_mem [MAX_TYPES];
   sml_pkg::tbl_entry_type tbl_rd_ff;

   logic [2:0]                        state_ff, state_in;
   logic [sml_pkg::CNT_REG_W-1:0]     num_types_ff, num_types_in;
   logic [sml_pkg::IDX_W-1:0]         idx_ff, idx_in;
   logic [sml_pkg::COUNT_W-1:0]       count_ff, count_in;
   logic                              last_ff, last_in;
   logic [W-1:0]                      ro_ff, ro_in;
   logic [sml_pkg::SIZE_W-1:0]        lg_len_ff, lg_len_in;
   logic [AW-1:0]                     lg_align_ff, lg_align_in;
   logic                              err_ff, err_in;
   logic [W-1:0]                      len_ff, len_in;
   logic [W-1:0]                      off_ff, off_in;
   logic [W-1:0]                      total_ff, total_in;
   logic [sml_pkg::STATUS_W-1:0]      status_ff, status_in;
   logic [W-1:0]                      div_num_ff, div_num_in;
   logic [AW-1:0]                     div_rem_ff, div_rem_in;
   logic [AW-1:0]                     div_align_ff, div_align_in;
   logic [1:0]                        div_cnt_ff, div_cnt_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [sml_pkg::RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;
   logic [sml_pkg::STATUS_W-1:0]      rsp_user_ff, rsp_user_in;
   logic                              rsp_last_ff, rsp_last_in;

   logic                              req_fire;
   logic [sml_pkg::IDX_W-1:0]         req_idx;
   logic [WIDE_W-1:0]                 req_idx_wide;
   logic [WIDE_W-1:0]                 idx_wide;
   logic [ADDR_W-1:0]                 req_addr;
   logic                              load_en;
   logic                              read_en;
   logic [AW-1:0]                     step_rem;
   logic [W-1:0]                      step_num;
   logic [W-1:0]                      pad_val;
   logic [sml_pkg::COUNT_W-1:0]       count_eff;
   logic [W-1:0]                      sum_val;
   logic                              idx_bad;

   assign req_tready   = (state_ff == S_IDLE);
   assign req_fire     = req_tvalid && req_tready;
   assign req_idx      = req_tdata[4:0];
   assign req_idx_wide = {{(WIDE_W - sml_pkg::IDX_W){1'b0}}, req_idx};
   assign idx_wide     = {{(WIDE_W - sml_pkg::IDX_W){1'b0}}, idx_ff};
   assign req_addr     = req_idx_wide[ADDR_W-1:0];
   assign load_en      = req_fire && (req_tuser == sml_pkg::REQ_LOAD) &&
                         (req_idx_wide < MAX_TYPES_W);
   assign read_en      = req_fire && (req_tuser == sml_pkg::REQ_MEMBER);

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (load_en) begin
         tbl_mem[req_addr] <= '{size: req_tdata[20:5], align: req_tdata[28:21]};
      end
      if (read_en) begin
         tbl_rd_ff <= tbl_mem[req_addr];
      end
   end

   // remainder step: eight dividend bits per cycle
   always_comb begin
      logic [AW:0]  r;
      logic [W-1:0] d;
      r = {1'b0, div_rem_ff};
      d = div_num_ff;
      for (int i = 0; i < 8; i++) begin
         r = {r[AW-1:0], d[W-1]};
         d = {d[W-2:0], 1'b0};
         if (r >= {1'b0, div_align_ff}) begin
            r = r - {1'b0, div_align_ff};
         end
      end
      step_rem = r[AW-1:0];
      step_num = d;
   end

   assign pad_val   = (step_rem != '0) ?
                      ro_ff + {{(W - AW){1'b0}}, div_align_ff} - {{(W - AW){1'b0}}, step_rem} :
                      ro_ff;
   assign count_eff = (count_ff == '0) ? sml_pkg::COUNT_W'(1) : count_ff;
   assign sum_val   = ro_ff + len_ff;
   assign idx_bad   = ({1'b0, idx_ff} >= num_types_ff) || (idx_wide >= MAX_TYPES_W);

   always_comb begin
      state_in      = state_ff;
      num_types_in  = num_types_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      last_in       = last_ff;
      ro_in         = ro_ff;
      lg_len_in     = lg_len_ff;
      lg_align_in   = lg_align_ff;
      err_in        = err_ff;
      len_in        = len_ff;
      off_in        = off_ff;
      total_in      = total_ff;
      status_in     = status_ff;
      div_num_in    = div_num_ff;
      div_rem_in    = div_rem_ff;
      div_align_in  = div_align_ff;
      div_cnt_in    = div_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_valid && csr_ready) begin
         num_types_in = csr_wdata;
      end

      case (state_ff)
         S_IDLE: begin
            if (read_en) begin
               idx_in   = req_idx;
               count_in = req_tdata[44:29];
               last_in  = req_tlast;
               state_in = S_READ;
            end
         end
         S_READ: begin
            off_in   = '0;
            len_in   = '0;
            total_in = '0;
            if (err_ff) begin
               status_in = sml_pkg::STATUS_SKIPPED;
               state_in  = S_DONE;
            end else if (idx_bad) begin
               status_in = sml_pkg::STATUS_BAD;
               err_in    = 1'b1;
               state_in  = S_DONE;
            end else begin
               status_in = sml_pkg::STATUS_OK;
               len_in    = W'(tbl_rd_ff.size) * W'(count_eff);
               if ((tbl_rd_ff.align > AW'(1)) && (tbl_rd_ff.size > lg_len_ff)) begin
                  lg_len_in   = tbl_rd_ff.size;
                  lg_align_in = tbl_rd_ff.align;
               end
               if ((ro_ff != '0) && (tbl_rd_ff.align > AW'(1))) begin
                  div_num_in   = ro_ff;
                  div_rem_in   = '0;
                  div_align_in = tbl_rd_ff.align;
                  div_cnt_in   = '0;
                  state_in     = S_PAD1;
               end else begin
                  state_in = S_ADD;
               end
            end
         end
         S_PAD1: begin
            div_num_in = step_num;
            div_rem_in = step_rem;
            div_cnt_in = div_cnt_ff + 2'd1;
            if (div_cnt_ff == 2'd3) begin
               ro_in    = pad_val;
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            off_in   = ro_ff;
            ro_in    = sum_val;
            total_in = '0;
            state_in = S_DONE;
            if (last_ff) begin
               if ((lg_len_ff != '0) && (lg_align_ff > AW'(1))) begin
                  div_num_in   = sum_val;
                  div_rem_in   = '0;
                  div_align_in = lg_align_ff;
                  div_cnt_in   = '0;
                  state_in     = S_PAD2;
               end else begin
                  total_in = sum_val;
               end
            end
         end
         S_PAD2: begin
            div_num_in = step_num;
            div_rem_in = step_rem;
            div_cnt_in = div_cnt_ff + 2'd1;
            if (div_cnt_ff == 2'd3) begin
               total_in = pad_val;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {total_ff, len_ff, off_ff};
               rsp_user_in  = status_ff;
               rsp_last_in  = last_ff;
               if (last_ff) begin
                  ro_in       = '0;
                  lg_len_in   = '0;
                  lg_align_in = '0;
                  err_in      = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         num_types_ff  <= sml_pkg::CNT_REG_W'(1);
         ro_ff         <= '0;
         lg_len_ff     <= '0;
         lg_align_ff   <= '0;
         err_ff        <= 1'b0;
         div_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         num_types_ff  <= num_types_in;
         ro_ff         <= ro_in;
         lg_len_ff     <= lg_len_in;
         lg_align_ff   <= lg_align_in;
         err_ff        <= err_in;
         div_cnt_ff    <= div_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      count_ff     <= count_in;
      last_ff      <= last_in;
      len_ff       <= len_in;
      off_ff       <= off_in;
      total_ff     <= total_in;
      status_ff    <= status_in;
      div_num_ff   <= div_num_in;
      div_rem_ff   <= div_rem_in;
      div_align_ff <= div_align_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule

`default_nettype wire

// ===== tb/struct_member_layout_unit_test.sv =====
`timescale 1ns / 1ps

module struct_member_layout_unit_test;

   localparam int SLOTS       = 32;
   localparam int SETTLE      = 24;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RAND_PHASES = 8;
   localparam int PHASE_ITEMS = 220;
   localparam int LONG_HOLD   = 400;

   typedef struct {
      logic                          req_type;
      logic [sml_pkg::IDX_W-1:0]     idx;
      logic [sml_pkg::SIZE_W-1:0]    size;
      logic [sml_pkg::ALIGN_W-1:0]   align;
      logic [sml_pkg::COUNT_W-1:0]   count;
      logic                          last;
   } layout_req_type;

   typedef struct {
      logic [sml_pkg::WORD_W-1:0]    offset;
      logic [sml_pkg::WORD_W-1:0]    length;
      logic [sml_pkg::STATUS_W-1:0]  status;
      logic [sml_pkg::WORD_W-1:0]    total;
      logic                          is_last;
   } member_layout_type;

   class layout_scoreboard_type;
      logic [sml_pkg::SIZE_W-1:0]    size_tbl[SLOTS];
      logic [sml_pkg::ALIGN_W-1:0]   align_tbl[SLOTS];
      logic [sml_pkg::CNT_REG_W-1:0] type_limit = 6'd1;
      logic [sml_pkg::WORD_W-1:0]    offset_acc = '0;
      logic [sml_pkg::SIZE_W-1:0]    widest_len = '0;
      logic [sml_pkg::ALIGN_W-1:0]   widest_align = '0;
      bit                            struct_failed = 1'b0;
      member_layout_type             pending_layouts[$];
      int errors = 0;
      int loads = 0;
      int members = 0;
      int structs = 0;
      int bad_types = 0;
      int skipped = 0;
      int count_writes = 0;

      function int pending();
         return pending_layouts.size();
      endfunction

      function void set_count(logic [sml_pkg::CNT_REG_W-1:0] v);
         type_limit = v;
         count_writes++;
      endfunction

      function logic [sml_pkg::WORD_W-1:0] pad_to(logic [sml_pkg::WORD_W-1:0] off,
                                                  logic [sml_pkg::WORD_W-1:0] align);
         logic [sml_pkg::WORD_W-1:0] rem;
         if (align <= 1) return off;
         rem = off % align;
         if (rem != 0) off = off + (align - rem);
         return off;
      endfunction

      function void clear_struct();
         offset_acc = '0;
         widest_len = '0;
         widest_align = '0;
         struct_failed = 1'b0;
      endfunction

      function void note_request(layout_req_type it);
         member_layout_type r;
         logic [sml_pkg::WORD_W-1:0] tsz, tal, cnt;
         if (it.req_type == sml_pkg::REQ_LOAD) begin
            size_tbl[it.idx] = it.size;
            align_tbl[it.idx] = it.align;
            loads++;
            return;
         end
         members++;
         r.offset = '0;
         r.length = '0;
         r.total = '0;
         r.status = sml_pkg::STATUS_OK;
         r.is_last = it.last;
         if (struct_failed) begin
            r.status = sml_pkg::STATUS_SKIPPED;
            skipped++;
         end else if (int'(it.idx) >= int'(type_limit)) begin
            r.status = sml_pkg::STATUS_BAD;
            struct_failed = 1'b1;
            bad_types++;
         end else begin
            tsz = {16'b0, size_tbl[it.idx]};
            tal = {24'b0, align_tbl[it.idx]};
            cnt = (it.count == 0) ? 32'd1 : {16'b0, it.count};
            if (tal > 1 && tsz > {16'b0, widest_len}) begin
               widest_len = tsz[sml_pkg::SIZE_W-1:0];
               widest_align = tal[sml_pkg::ALIGN_W-1:0];
            end
            if (offset_acc != 0) offset_acc = pad_to(offset_acc, tal);
            r.offset = offset_acc;
            r.length = tsz * cnt;
            offset_acc = offset_acc + r.length;
            if (it.last)
               r.total = (widest_len != 0) ? pad_to(offset_acc, {24'b0, widest_align})
                                           : offset_acc;
         end
         if (it.last) begin
            clear_struct();
            structs++;
         end
         pending_layouts.push_back(r);
      endfunction

      task report_mismatch(string what, logic [sml_pkg::WORD_W-1:0] want,
                           logic [sml_pkg::WORD_W-1:0] got);
         errors++;
         if (errors <= 100)
            $display("[%0t] MISMATCH %s: expected 0x%08h, got 0x%08h", $time, what, want, got);
      endtask

      task check_layout(logic [sml_pkg::WORD_W-1:0] off, logic [sml_pkg::WORD_W-1:0] len,
                        logic [sml_pkg::WORD_W-1:0] total,
                        logic [sml_pkg::STATUS_W-1:0] st, logic last);
         member_layout_type want;
         if (pending_layouts.size() == 0) begin
            report_mismatch("unexpected result beat, offset", '0, off);
            return;
         end
         want = pending_layouts.pop_front();
         if (off !== want.offset) report_mismatch("member_offset", want.offset, off);
         if (len !== want.length) report_mismatch("member_length", want.length, len);
         if (total !== want.total) report_mismatch("struct_total", want.total, total);
         if (st !== want.status) report_mismatch("status", {30'b0, want.status}, {30'b0, st});
         if (last !== want.is_last)
            report_mismatch("is_last", {31'b0, want.is_last}, {31'b0, last});
      endtask
   endclass

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [sml_pkg::REQ_DATA_W-1:0]     req_tdata = '0;
   logic                               req_tuser = 1'b0;
   logic                               req_tlast = 1'b0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [sml_pkg::RSP_DATA_W-1:0]     rsp_tdata;
   logic [sml_pkg::STATUS_W-1:0]       rsp_tuser;
   logic                               rsp_tlast;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [sml_pkg::CNT_REG_W-1:0]      csr_wdata = '0;

   layout_scoreboard_type board = new();
   layout_req_type req_plan[$];
   bit slot_loaded[SLOTS];
   int rx_hold = 0;
   int cycle_count = 0;

   struct_member_layout_unit #(.MAX_TYPES(SLOTS)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      // type_index[4:0], type_size[20:5], type_alignment[28:21], array_count[44:29]
      .req_tdata  (req_tdata),
      // req_type[0]
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      // member_offset[31:0], member_length[63:32], struct_total[95:64]
      .rsp_tdata  (rsp_tdata),
      // status[1:0]
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, board.pending());
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_layout(rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64],
                            rsp_tuser, rsp_tlast);
   end

   initial begin : rx_side
      int mode;
      int span;
      logic [2:0] tick;
      tick = '0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(40, 300);
         repeat (span) begin
            @(negedge clock);
            tick = tick + 1'b1;
            if (rx_hold > 0) begin
               rx_hold--;
               rsp_tready <= 1'b0;
            end else begin
               case (mode)
                  0: rsp_tready <= 1'b1;
                  1: rsp_tready <= ($urandom_range(0, 9) < 7);
                  2: rsp_tready <= ($urandom_range(0, 9) < 3);
                  default: rsp_tready <= (tick == 3'd0);
               endcase
            end
         end
      end
   end

   function automatic void push_load(int idx, logic [sml_pkg::SIZE_W-1:0] size,
                                     logic [sml_pkg::ALIGN_W-1:0] align, logic last);
      layout_req_type it;
      it.req_type = sml_pkg::REQ_LOAD;
      it.idx = idx[sml_pkg::IDX_W-1:0];
      it.size = size;
      it.align = align;
      it.count = sml_pkg::COUNT_W'($urandom);
      it.last = last;
      slot_loaded[idx] = 1'b1;
      req_plan.push_back(it);
   endfunction

   function automatic void push_member(int idx, logic [sml_pkg::COUNT_W-1:0] count,
                                       logic last);
      layout_req_type it;
      it.req_type = sml_pkg::REQ_MEMBER;
      it.idx = idx[sml_pkg::IDX_W-1:0];
      it.size = sml_pkg::SIZE_W'($urandom);
      it.align = sml_pkg::ALIGN_W'($urandom);
      it.count = count;
      it.last = last;
      req_plan.push_back(it);
   endfunction

   function automatic logic [sml_pkg::SIZE_W-1:0] rand_size();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 16'hFFFF;
         2, 3, 4: return sml_pkg::SIZE_W'($urandom_range(0, 16));
         5, 6: return sml_pkg::SIZE_W'(1 << $urandom_range(0, 6));
         default: return sml_pkg::SIZE_W'($urandom);
      endcase
   endfunction

   function automatic logic [sml_pkg::ALIGN_W-1:0] rand_align();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 8'd1;
         2: return 8'hFF;
         3: return sml_pkg::ALIGN_W'($urandom_range(0, 255));
         4, 5: return sml_pkg::ALIGN_W'($urandom_range(3, 13));
         default: return sml_pkg::ALIGN_W'(1 << $urandom_range(1, 5));
      endcase
   endfunction

   function automatic logic [sml_pkg::COUNT_W-1:0] rand_count();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 16'hFFFF;
         2: return sml_pkg::COUNT_W'($urandom);
         default: return sml_pkg::COUNT_W'($urandom_range(1, 4));
      endcase
   endfunction

   // valid picks come only from loaded slots, so no unwritten entry is ever used
   function automatic int pick_type(int tc);
      int lim;
      int pool[$];
      lim = (tc > SLOTS) ? SLOTS : tc;
      if (lim < SLOTS && (lim == 0 || $urandom_range(0, 99) < 8))
         return $urandom_range(lim, SLOTS - 1);
      for (int s = 0; s < lim; s++)
         if (slot_loaded[s]) pool.push_back(s);
      if (pool.size() == 0) begin
         pool.push_back($urandom_range(0, lim - 1));
         push_load(pool[0], rand_size(), rand_align(), 1'b0);
      end
      return pool[$urandom_range(0, pool.size() - 1)];
   endfunction

   task automatic build_random(int n, int tc);
      int start;
      int len;
      start = req_plan.size();
      while (req_plan.size() - start < n) begin
         if ($urandom_range(0, 99) < 12) begin
            push_load($urandom_range(0, SLOTS - 1), rand_size(), rand_align(),
                      1'($urandom_range(0, 1)));
         end else begin
            len = $urandom_range(1, 8);
            for (int m = 0; m < len; m++) begin
               if ($urandom_range(0, 99) < 4)
                  push_load($urandom_range(0, SLOTS - 1), rand_size(), rand_align(), 1'b0);
               // drop the final marker now and then so runs merge
               push_member(pick_type(tc), rand_count(),
                           (m == len - 1) && ($urandom_range(0, 99) >= 5));
            end
         end
      end
   endtask

   task automatic send_plan();
      layout_req_type it;
      int burst_left;
      int gap;
      burst_left = $urandom_range(1, 40);
      while (req_plan.size() != 0) begin
         it = req_plan.pop_front();
         if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 40);
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left--;
         req_tvalid <= 1'b1;
         req_tuser <= it.req_type;
         req_tlast <= it.last;
         req_tdata <= {3'b0, it.count, it.align, it.size, it.idx};
         do @(posedge clock); while (!req_tready);
         board.note_request(it);
         @(negedge clock);
      end
      req_tvalid <= 1'b0;
   endtask

   task automatic write_count(logic [sml_pkg::CNT_REG_W-1:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      board.set_count(v);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin : main_flow
      int tc;
      int tc_list[6];
      tc_list = '{1, 63, 0, 32, 9, 31};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_count(6'd32);
      @(negedge clock);
      push_load(0, 16'hFFFF, 8'hFF, 1'b0);
      push_load(31, 16'h0000, 8'h00, 1'b1);
      push_load(1, 16'd4, 8'd4, 1'b0);
      push_load(2, 16'd1, 8'd1, 1'b0);
      push_load(3, 16'd8, 8'd8, 1'b0);
      push_load(4, 16'd3, 8'd3, 1'b0);
      push_load(5, 16'd2, 8'd2, 1'b0);
      push_load(6, 16'd2, 8'd16, 1'b0);
      push_member(2, 16'd0, 1'b0);
      push_member(1, 16'd1, 1'b0);
      push_member(4, 16'd5, 1'b0);
      push_member(3, 16'd1, 1'b1);
      push_member(5, 16'd1, 1'b0);
      push_member(6, 16'd1, 1'b0);
      push_member(2, 16'd1, 1'b1);
      push_member(2, 16'd1, 1'b1);
      push_member(0, 16'hFFFF, 1'b0);
      push_member(0, 16'hFFFF, 1'b0);
      push_member(31, 16'd0, 1'b1);
      send_plan();
      wait_idle();

      write_count(6'd6);
      @(negedge clock);
      push_member(1, 16'd2, 1'b0);
      push_member(7, 16'd1, 1'b0);
      push_member(1, 16'd1, 1'b0);
      push_member(2, 16'd1, 1'b1);
      push_member(6, 16'd1, 1'b1);
      send_plan();
      wait_idle();

      for (int p = 0; p < RAND_PHASES; p++) begin
         tc = (p < 6) ? tc_list[p] : $urandom_range(1, 32);
         // starve the result side so the block backs up into its input
         if (p == 3) rx_hold = LONG_HOLD;
         write_count(tc[sml_pkg::CNT_REG_W-1:0]);
         build_random(PHASE_ITEMS, tc);
         @(negedge clock);
         send_plan();
         wait_idle();
      end

      if (board.pending() != 0)
         board.report_mismatch("results never delivered", board.pending(), 0);
      $display("Run covered %0d table loads and %0d members in %0d structures",
               board.loads, board.members, board.structs);
      $display("  %0d invalid types, %0d skipped members, %0d type limit writes",
               board.bad_types, board.skipped, board.count_writes);
      if (board.errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
